@@ design/md5_pkg.sv @@
// MD5 stream hasher package: transfer payload types, initial chaining values,
// round constant and rotate amount tables. No dependencies.
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } data_item_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
  } digest_t;

  localparam logic [31:0] INIT_A = 32'h6745_2301;
  localparam logic [31:0] INIT_B = 32'hEFCD_AB89;
  localparam logic [31:0] INIT_C = 32'h98BA_DCFE;
  localparam logic [31:0] INIT_D = 32'h1032_5476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         BLK_WORDS  = 16;
  localparam logic [6:0] FULL_FILL  = 7'd64;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [6:0] LEN_OFFSET = 7'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

@@ design/md5_stream_hasher.sv @@
// MD5 stream hasher top level: byte buffer, round sequencer and digest register.
// Depends on md5_pkg for payload types, initial values and round tables.
//
// Usage:
//   data channel: one message byte per transfer (byte_present marks a real
//   byte); message_end closes the message, with or without a byte, so an
//   empty message is a single transfer with byte_present low.
//   digest channel: one transfer per message, the four chaining words.
// Flow:
//   bytes are taken one per cycle while the sequencer is idle. The 64th byte
//   of a block starts the compression: one shared round unit runs 64 rounds,
//   one per cycle, then the update state folds the result into the chaining
//   words; data_stall stays high throughout. A message end runs one or two
//   padded blocks (two whenever its byte fills a block or the block then holds
//   56 bytes or more), then the emit state loads the digest register.
// Reset clears the sequencer, the byte count and the chaining words; the
// byte buffer is not cleared since every byte is written before it is read.
// A stalled digest holds in its register; new bytes are still taken, and
// only the next message end waits until the held digest has gone out.
module md5_stream_hasher (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::data_item_t data,
  input  logic                data_valid,
  output logic                data_stall,
  output md5_pkg::digest_t    digest,
  output logic                digest_valid,
  input  logic                digest_stall
);
  import md5_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  state_t      state;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] a, b, c, d;
  logic [5:0]  round_idx;
  logic [60:0] byte_count;
  // Current block descriptor: bytes below fill come from the buffer, mark puts
  // the pad byte at fill, len places the bit length in the last eight bytes.
  logic [6:0]  fill;
  logic        mark;
  logic        len;
  logic        last;
  // A length-only block still to run after the current one.
  logic        tail_pend;
  logic        tail_mark;

  logic [31:0] blk_words [BLK_WORDS];

  logic        accept;
  logic [5:0]  pos;
  logic [5:0]  end_pos;
  logic [1:0]  group;
  logic [3:0]  r4;
  logic [3:0]  k;
  logic [31:0] f;
  logic [31:0] m_word;
  logic [31:0] t;
  logic [31:0] rot_t;
  logic [63:0] rot_wide;
  logic [63:0] len_bits;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;

  assign data_stall = (state != ST_IDLE);
  assign accept     = data_valid && !data_stall;
  assign pos        = byte_count[5:0];
  assign end_pos    = data.byte_present ? pos + 6'd1 : pos;
  assign len_bits   = {byte_count, 3'b000};

  assign sum_a = chain_a + a;
  assign sum_b = chain_b + b;
  assign sum_c = chain_c + c;
  assign sum_d = chain_d + d;

  // Round function, message index and the padded message word.
  always_comb begin
    logic [5:0] idx;
    logic [7:0] byte_val;
    group = round_idx[5:4];
    r4    = round_idx[3:0];
    case (group)
      2'd0: begin
        f = d ^ (b & (c ^ d));
        k = r4;
      end
      2'd1: begin
        f = c ^ (d & (b ^ c));
        k = r4 * 4'd5 + 4'd1;
      end
      2'd2: begin
        f = b ^ c ^ d;
        k = r4 * 4'd3 + 4'd5;
      end
      default: begin
        f = c ^ (b | ~d);
        k = r4 * 4'd7;
      end
    endcase
    m_word = blk_words[k];
    for (int j = 0; j < 4; j++) begin
      idx = {k, 2'(j)};
      if (len && ({1'b0, idx} >= LEN_OFFSET)) begin
        byte_val = len_bits[8 * idx[2:0] +: 8];
      end else if ({1'b0, idx} < fill) begin
        byte_val = m_word[8 * j +: 8];
      end else if (mark && ({1'b0, idx} == fill)) begin
        byte_val = PAD_BYTE;
      end else begin
        byte_val = 8'h00;
      end
      m_word[8 * j +: 8] = byte_val;
    end
    t        = a + f + round_const(round_idx) + m_word;
    rot_wide = {t, t} << rot_amount(round_idx);
    rot_t    = rot_wide[63:32];
  end

  // Byte buffer: little-endian words, written one byte per accepted transfer that carries a byte.
  always_ff @(posedge clk) begin
    if (accept && data.byte_present) begin
      blk_words[pos[5:2]][8 * pos[1:0] +: 8] <= data.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chain_a      <= INIT_A;
      chain_b      <= INIT_B;
      chain_c      <= INIT_C;
      chain_d      <= INIT_D;
      byte_count   <= '0;
      tail_pend    <= 1'b0;
      tail_mark    <= 1'b0;
      last         <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      // Drop the digest once its transfer completes; an emit reloads it instead.
      if (digest_valid && !digest_stall && state != ST_EMIT) begin
        digest_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (data.byte_present) begin
              byte_count <= byte_count + 61'd1;
            end
            a         <= chain_a;
            b         <= chain_b;
            c         <= chain_c;
            d         <= chain_d;
            round_idx <= '0;
            if (data.byte_present && pos == LAST_POS) begin
              // Full data block; an end here needs one length block after.
              fill      <= FULL_FILL;
              mark      <= 1'b0;
              len       <= 1'b0;
              last      <= 1'b0;
              tail_pend <= data.message_end;
              tail_mark <= 1'b1;
              state     <= ST_ROUND;
            end else if (data.message_end) begin
              fill  <= {1'b0, end_pos};
              mark  <= 1'b1;
              state <= ST_ROUND;
              if ({1'b0, end_pos} < LEN_OFFSET) begin
                len       <= 1'b1;
                last      <= 1'b1;
                tail_pend <= 1'b0;
              end else begin
                // No room for the length: it goes in a block of its own.
                len       <= 1'b0;
                last      <= 1'b0;
                tail_pend <= 1'b1;
                tail_mark <= 1'b0;
              end
            end
          end
        end
        ST_ROUND: begin
          a         <= d;
          b         <= b + rot_t;
          c         <= b;
          d         <= c;
          round_idx <= round_idx + 6'd1;
          if (round_idx == LAST_ROUND) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          chain_a <= sum_a;
          chain_b <= sum_b;
          chain_c <= sum_c;
          chain_d <= sum_d;
          if (tail_pend) begin
            a         <= sum_a;
            b         <= sum_b;
            c         <= sum_c;
            d         <= sum_d;
            round_idx <= '0;
            fill      <= '0;
            mark      <= tail_mark;
            len       <= 1'b1;
            last      <= 1'b1;
            tail_pend <= 1'b0;
            state     <= ST_ROUND;
          end else if (last) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // Hold until the previous digest has been taken.
          if (!digest_valid || !digest_stall) begin
            digest.digest_word0 <= chain_a;
            digest.digest_word1 <= chain_b;
            digest.digest_word2 <= chain_c;
            digest.digest_word3 <= chain_d;
            digest_valid        <= 1'b1;
            chain_a             <= INIT_A;
            chain_b             <= INIT_B;
            chain_c             <= INIT_C;
            chain_d             <= INIT_D;
            byte_count          <= '0;
            last                <= 1'b0;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
